### rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the 3x3 Laplacian sharpening stream.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam int unsigned WIDTH_REG_W    = 11;
    localparam int unsigned HEIGHT_REG_W   = 13;
    localparam int unsigned CHANNEL_REG_W  = 3;
    localparam logic [WIDTH_REG_W-1:0]   WIDTH_RESET   = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0]  HEIGHT_RESET  = 13'd480;
    localparam logic [CHANNEL_REG_W-1:0] CHANNEL_RESET = 3'd3;

    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned MIN_CHANNELS = 1;

    // Kernel
    localparam int unsigned GAIN  = 5;
    localparam int unsigned ACC_W = 12;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] sample;
        logic       frame_start;
    } lss_in_t;

    typedef struct packed {
        logic [7:0] sharpened;
        logic       run_last;
        logic       frame_last;
    } lss_out_t;

    // One entry of the row store: the row two above and the row above.
    typedef struct packed {
        logic [7:0] older;
        logic [7:0] newer;
    } lss_entry_t;

    // Position of an item within the frame.
    typedef struct packed {
        logic has_result;
        logic last_row;
        logic interior;
        logic row_end;
    } lss_pos_flags_t;

    // All results caused by one item.
    typedef struct packed {
        logic [7:0] sharpened;
        logic       first_run_last;
        logic       pair;
        logic       final_frame_last;
    } lss_bundle_t;

endpackage

### rtl/lss_position.sv
// ----------------------------------------------------------------------------
// lss_position
// Column and row counters; classifies each accepted item within the frame.
// ----------------------------------------------------------------------------
module lss_position
    import lss_pkg::*;
#(
    parameter int COL_W = 13,
    parameter int H_W   = 13,
    parameter int C_W   = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             frame_start,
    input  logic [COL_W-1:0] row_len,
    input  logic [H_W-1:0]   height,
    input  logic [C_W-1:0]   chans,
    output logic [COL_W-1:0] col,
    output logic [COL_W-1:0] right_col,
    output lss_pos_flags_t   flags
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [H_W-1:0]   row_reg;
    logic [H_W-1:0]   row_next;
    logic [H_W-1:0]   row_cur;
    logic [COL_W-1:0] chans_ext;

    assign chans_ext = COL_W'(chans);

    always_comb
    begin
        col      = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        // A geometry change can leave the counters past the new bounds.
        if (col >= row_len)
        begin
            col     = '0;
            row_cur = row_cur + 1'b1;
        end
        if (row_cur >= height)
        begin
            row_cur = '0;
        end

        right_col = col + chans_ext;

        flags.has_result = (row_cur != '0);
        flags.last_row   = (row_cur == height - 1'b1);
        flags.interior   = (row_cur >= H_W'(2)) && (col >= chans_ext)
                           && (col < row_len - chans_ext);
        flags.row_end    = (col == row_len - 1'b1);

        if (flags.row_end)
        begin
            col_next = '0;
            row_next = flags.last_row ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_next = col + 1'b1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### rtl/lss_line_mem.sv
// ----------------------------------------------------------------------------
// lss_line_mem
// Row store of two rows, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lss_line_mem
    import lss_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  lss_entry_t        wr_data,
    output lss_entry_t        rd_data_a,
    output logic [7:0]        rd_newer_b
);

    lss_entry_t store_mem [DEPTH];

    lss_entry_t rd_a_reg;
    lss_entry_t rd_b_reg;
    lss_entry_t fwd_data_reg;
    logic       fwd_a_reg;
    logic       fwd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // A write in the same cycle as a read of that entry is passed through.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg     <= store_mem[rd_addr_a];
            rd_b_reg     <= store_mem[rd_addr_b];
            fwd_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data_a  = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign rd_newer_b = fwd_b_reg ? fwd_data_reg.newer : rd_b_reg.newer;

endmodule

### rtl/lss_out_queue.sv
// ----------------------------------------------------------------------------
// lss_out_queue
// Small queue of per-item result bundles, unpacked into single result items.
// ----------------------------------------------------------------------------
module lss_out_queue
    import lss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lss_bundle_t       push_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lss_out_t          out_data,
    output logic [QCNT_W-1:0] level
);

    lss_bundle_t       q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              phase_reg;
    logic              phase_next;
    logic              pop;
    lss_bundle_t       head;

    assign head      = q_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign level     = count_reg;

    // The second result of a pair is always a zero for the item itself.
    always_comb
    begin
        out_data.sharpened  = phase_reg ? 8'd0 : head.sharpened;
        out_data.run_last   = phase_reg ? 1'b1 : head.first_run_last;
        out_data.frame_last = phase_reg ? head.final_frame_last : 1'b0;

        pop        = 1'b0;
        phase_next = phase_reg;
        if (out_valid && !out_stall)
        begin
            if (head.pair && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### rtl/laplacian_sharpen_3x3_stream.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream
// 3x3 Laplacian sharpening of a channel-interleaved 8-bit sample stream.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (lss_in_t)
//  out      output     out_valid / out_stall  out_data  (lss_out_t)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per clock cycle while in_stall is low. Its row store
// read is issued on acceptance, the kernel and write-back follow in the next
// cycle, and its results reach the output queue then. Items of the last row
// give two results each, so there the output port sets the pace. in_stall
// rises when the four-bundle result queue cannot take the items in flight.
// Reset clears counters and control; the row store needs no clearing.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_stream
    import lss_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_HEIGHT   = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lss_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lss_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH      = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COL_W      = $clog2(DEPTH + 1);
    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int H_W        = $clog2(MAX_HEIGHT + 1);
    localparam int C_W        = $clog2(MAX_CHANNELS + 1);
    localparam int HIST_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration
    logic [WIDTH_REG_W-1:0]   width_reg;
    logic [HEIGHT_REG_W-1:0]  height_reg;
    logic [CHANNEL_REG_W-1:0] chans_reg;
    logic [W_W-1:0]           width_cl;
    logic [H_W-1:0]           height_cl;
    logic [C_W-1:0]           chans_cl;
    logic [COL_W-1:0]         row_len;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chans_reg  <= CHANNEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                CFG_CHANNEL_COUNT: chans_reg  <= cfg_data[CHANNEL_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(width_reg) < MIN_DIM)
            width_cl = W_W'(MIN_DIM);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_cl = W_W'(MAX_WIDTH);
        else
            width_cl = W_W'(width_reg);

        if (32'(height_reg) < MIN_DIM)
            height_cl = H_W'(MIN_DIM);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            height_cl = H_W'(MAX_HEIGHT);
        else
            height_cl = H_W'(height_reg);

        if (32'(chans_reg) < MIN_CHANNELS)
            chans_cl = C_W'(MIN_CHANNELS);
        else if (32'(chans_reg) > 32'(MAX_CHANNELS))
            chans_cl = C_W'(MAX_CHANNELS);
        else
            chans_cl = C_W'(chans_reg);
    end

    assign row_len = COL_W'(width_cl) * COL_W'(chans_cl);

    // Acceptance and position
    logic              in_accept;
    logic [QCNT_W-1:0] q_level;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  right_col;
    lss_pos_flags_t    pos_flags;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_sample_reg;
    lss_pos_flags_t    s1_flags_reg;

    // Room is kept for the item in the kernel stage and the one taken now.
    assign in_stall  = ({1'b0, q_level} + (QCNT_W+1)'(s1_valid_reg))
                       >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign in_accept = in_valid && !in_stall;

    lss_position #(
        .COL_W (COL_W),
        .H_W   (H_W),
        .C_W   (C_W)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .frame_start (in_data.frame_start),
        .row_len     (row_len),
        .height      (height_cl),
        .chans       (chans_cl),
        .col         (col),
        .right_col   (right_col),
        .flags       (pos_flags)
    );

    // Row store
    lss_entry_t centre_entry;
    logic [7:0] right_val;
    lss_entry_t wb_entry;

    assign wb_entry.older = centre_entry.newer;
    assign wb_entry.newer = s1_sample_reg;

    lss_line_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .clk        (clk),
        .rd_en      (in_accept),
        .rd_addr_a  (ADDR_W'(col)),
        .rd_addr_b  (ADDR_W'(right_col)),
        .wr_en      (s1_valid_reg),
        .wr_addr    (s1_addr_reg),
        .wr_data    (wb_entry),
        .rd_data_a  (centre_entry),
        .rd_newer_b (right_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg   <= ADDR_W'(col);
            s1_sample_reg <= in_data.sample;
            s1_flags_reg  <= pos_flags;
        end
    end

    // The left neighbour is the centre value seen one pixel, i.e. chans
    // items, earlier in the same row.
    logic [7:0] hist_reg [MAX_CHANNELS];
    logic [7:0] left_val;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            hist_reg[0] <= centre_entry.newer;
            for (int i = 1; i < MAX_CHANNELS; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign left_val = hist_reg[HIST_IDX_W'(chans_cl - 1'b1)];

    // Kernel
    logic [ACC_W-1:0] acc;
    logic [7:0]       clamped;
    lss_bundle_t      bundle;

    always_comb
    begin
        acc = ACC_W'(centre_entry.newer) * ACC_W'(GAIN)
              - ACC_W'(left_val) - ACC_W'(right_val)
              - ACC_W'(centre_entry.older) - ACC_W'(s1_sample_reg);
        if (acc[ACC_W-1])
            clamped = 8'd0;
        else if (acc > ACC_W'(255))
            clamped = 8'd255;
        else
            clamped = acc[7:0];

        bundle.sharpened        = s1_flags_reg.interior ? clamped : 8'd0;
        bundle.first_run_last   = !s1_flags_reg.last_row;
        bundle.pair             = s1_flags_reg.last_row;
        bundle.final_frame_last = s1_flags_reg.row_end;
    end

    lss_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg && s1_flags_reg.has_result),
        .push_data (bundle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .level     (q_level)
    );

endmodule
